>>> design/vud_pkg.sv
// shared types, constants and the coordinate match function for the uv dedup table
package vud_pkg;

   // widths fixed by the transaction fields
   localparam int VTX_W   = 12;
   localparam int COORD_W = 32;
   localparam int OUT_W   = 14;
   localparam int STAT_W  = 2;

   // running uv index counter width
   localparam int NEXT_W  = 15;

   // generation tag kept with each vertex count
   localparam int EPOCH_W = 8;

   localparam logic [STAT_W-1:0] ST_FOUND = 2'd0;
   localparam logic [STAT_W-1:0] ST_ADDED = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

   function automatic logic is_nan(input logic [COORD_W-1:0] x);
      is_nan = (x[COORD_W-2:0] > 31'h7F80_0000);
   endfunction

   // nan matches anything, +0 matches -0, otherwise exact bits
   function automatic logic coord_match(input logic [COORD_W-1:0] a,
                                        input logic [COORD_W-1:0] b);
      logic [COORD_W-1:0] both;
      both = a | b;
      coord_match = is_nan(a) || is_nan(b) || (a == b) || (both[COORD_W-2:0] == '0);
   endfunction

endpackage

>>> design/vud_count_tbl.sv
// per-vertex list length memory with generation tags
module vud_count_tbl #(
   parameter int MAX_VERTICES     = 4096,
   parameter int SLOTS_PER_VERTEX = 8,
   localparam int VA_W  = $clog2(MAX_VERTICES),
   localparam int CNT_W = $clog2(SLOTS_PER_VERTEX + 1)
) (
   input  logic                        clock,
   input  vud_pkg::mem_ctl_type        ctl,
   input  logic [VA_W-1:0]             addr,
   input  logic [CNT_W-1:0]            wr_count,
   input  logic [vud_pkg::EPOCH_W-1:0] epoch,
   output logic [CNT_W-1:0]            rd_count
);

   logic [vud_pkg::EPOCH_W+CNT_W-1:0] mem [MAX_VERTICES];
   logic [vud_pkg::EPOCH_W+CNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= {epoch, wr_count};
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   // an entry written under an older generation counts as empty
   assign rd_count = (rd_data_ff[vud_pkg::EPOCH_W+CNT_W-1:CNT_W] == epoch) ?
                     rd_data_ff[CNT_W-1:0] : '0;

endmodule

>>> design/vud_slot_tbl.sv
// per-vertex slot memory holding uv index and coordinates, with match compare
module vud_slot_tbl #(
   parameter int MAX_VERTICES     = 4096,
   parameter int SLOTS_PER_VERTEX = 8,
   localparam int SL_AW = $clog2(MAX_VERTICES * SLOTS_PER_VERTEX)
) (
   input  logic                        clock,
   input  vud_pkg::mem_ctl_type        ctl,
   input  logic [SL_AW-1:0]            addr,
   input  logic [vud_pkg::NEXT_W-1:0]  wr_idx,
   input  logic [vud_pkg::COORD_W-1:0] u_bits,
   input  logic [vud_pkg::COORD_W-1:0] v_bits,
   output logic                        hit,
   output logic [vud_pkg::NEXT_W-1:0]  hit_idx
);

   localparam int DW = vud_pkg::NEXT_W + 2 * vud_pkg::COORD_W;

   logic [DW-1:0] mem [MAX_VERTICES * SLOTS_PER_VERTEX];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= {wr_idx, u_bits, v_bits};
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign hit_idx = rd_data_ff[DW-1:2*vud_pkg::COORD_W];
   assign hit = vud_pkg::coord_match(rd_data_ff[2*vud_pkg::COORD_W-1:vud_pkg::COORD_W], u_bits)
             && vud_pkg::coord_match(rd_data_ff[vud_pkg::COORD_W-1:0], v_bits);

endmodule

>>> design/vertex_uv_dedup_table_top.sv
// uv dedup table top level: sequencer, index counter and result register
//
// One request transaction carries a face corner: vertex index, u and v bit patterns and
// a new_mesh flag. Each request gives exactly one response transaction with the uv index
// and a status (found, added, full). Both channels use valid/stall; a transaction moves
// on a clock edge with valid high and stall low.
// Items are worked one at a time. After a request is accepted, the length of that vertex's
// list (0 to SLOTS_PER_VERTEX) is read from the count memory; then the slot memory is read
// one slot per cycle and each read is compared in the next cycle, stopping at the first
// match. The next request can be accepted in the cycle after the response is loaded.
// The response sits in an output register; while the receiver stalls, the next request
// is accepted and searched, and it waits only if its own result is ready before the
// earlier one is taken.
// After reset the block sweeps the vertex count memory, one entry per cycle, through all
// MAX_VERTICES entries with req_stall high. new_mesh bumps a generation tag instead of
// clearing; every 256th new_mesh rolls the tag over and runs the same sweep first.
module vertex_uv_dedup_table_top #(
   parameter int MAX_VERTICES     = 4096,
   parameter int SLOTS_PER_VERTEX = 8,
   parameter int MAX_UV_ENTRIES   = 16384
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [vud_pkg::VTX_W-1:0]   req_vertex_index,
   input  logic [vud_pkg::COORD_W-1:0] req_u_bits,
   input  logic [vud_pkg::COORD_W-1:0] req_v_bits,
   input  logic                        req_new_mesh,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [vud_pkg::OUT_W-1:0]   rsp_uv_index,
   output logic [vud_pkg::STAT_W-1:0]  rsp_status
);

   localparam int VA_W  = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(SLOTS_PER_VERTEX + 1);
   localparam int SL_AW = $clog2(MAX_VERTICES * SLOTS_PER_VERTEX);
   localparam int NW    = vud_pkg::NEXT_W;
   localparam int EW    = vud_pkg::EPOCH_W;
   localparam int CW    = vud_pkg::COORD_W;

   localparam logic [VA_W-1:0] LAST_VTX = VA_W'(MAX_VERTICES - 1);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_START  = 3'd2;
   localparam logic [2:0] S_CNT    = 3'd3;
   localparam logic [2:0] S_SEARCH = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   // control state
   logic [2:0]          state_ff, state_in;
   logic [VA_W-1:0]     pass_ff, pass_in;
   logic                pend_ff, pend_in;
   logic [EW-1:0]       epoch_ff, epoch_in;
   logic [NW-1:0]       next_ff, next_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // item payload
   logic [VA_W-1:0]     vaddr_ff, vaddr_in;
   logic                in_range_ff, in_range_in;
   logic [CW-1:0]       u_ff, u_in;
   logic [CW-1:0]       v_ff, v_in;
   logic [SL_AW-1:0]    base_ff, base_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [CNT_W-1:0]    rd_i_ff, rd_i_in;
   logic [NW-1:0]       res_idx_ff, res_idx_in;
   logic [vud_pkg::STAT_W-1:0] res_st_ff, res_st_in;
   logic [vud_pkg::OUT_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [vud_pkg::STAT_W-1:0] rsp_st_ff, rsp_st_in;

   // memory side
   vud_pkg::mem_ctl_type cnt_ctl, slot_ctl;
   logic [VA_W-1:0]     cnt_addr;
   logic [CNT_W-1:0]    cnt_wr, cnt_rd;
   logic [SL_AW-1:0]    slot_addr;
   logic [CNT_W-1:0]    slot_sel;
   logic                slot_hit;
   logic [NW-1:0]       slot_hit_idx;

   logic                req_accept;
   logic [CNT_W-1:0]    cur_n;
   logic                can_add;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   // list length comes straight from memory in the cycle after the count read
   assign cur_n   = (state_ff == S_CNT) ? cnt_rd : n_ff;
   assign can_add = (cur_n < CNT_W'(SLOTS_PER_VERTEX))
                 && (32'(next_ff) < 32'(MAX_UV_ENTRIES));

   assign cnt_addr  = (state_ff == S_CLEAR) ? pass_ff : vaddr_ff;
   assign slot_addr = base_ff + SL_AW'(slot_sel);

   always_comb begin
      state_in     = state_ff;
      pass_in      = pass_ff;
      pend_in      = pend_ff;
      epoch_in     = epoch_ff;
      next_in      = next_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      vaddr_in     = vaddr_ff;
      in_range_in  = in_range_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      base_in      = base_ff;
      n_in         = n_ff;
      rd_i_in      = rd_i_ff;
      res_idx_in   = res_idx_ff;
      res_st_in    = res_st_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_st_in    = rsp_st_ff;
      cnt_ctl      = '0;
      slot_ctl     = '0;
      cnt_wr       = '0;
      slot_sel     = rd_i_ff;

      unique case (state_ff)
         S_CLEAR: begin
            cnt_ctl.wr_en = 1'b1;
            if (pass_ff == LAST_VTX) begin
               state_in = pend_ff ? S_START : S_IDLE;
               pend_in  = 1'b0;
            end else begin
               pass_in = pass_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               vaddr_in    = VA_W'(req_vertex_index);
               in_range_in = (32'(req_vertex_index) < 32'(MAX_VERTICES));
               u_in        = req_u_bits;
               v_in        = req_v_bits;
               state_in    = S_START;
               if (req_new_mesh) begin
                  next_in  = '0;
                  epoch_in = epoch_ff + 1'b1;
                  // tag rollover: old entries could alias, so sweep first
                  if (epoch_ff == '1) begin
                     pass_in  = '0;
                     pend_in  = 1'b1;
                     state_in = S_CLEAR;
                  end
               end
            end
         end
         S_START: begin
            rd_i_in = '0;
            base_in = SL_AW'(vaddr_ff) * SL_AW'(SLOTS_PER_VERTEX);
            if (in_range_ff) begin
               cnt_ctl.rd_en = 1'b1;
               state_in      = S_CNT;
            end else begin
               res_idx_in = '0;
               res_st_in  = vud_pkg::ST_FULL;
               state_in   = S_DONE;
            end
         end
         S_CNT, S_SEARCH: begin
            n_in = cur_n;
            priority if ((state_ff == S_SEARCH) && slot_hit) begin
               res_idx_in = slot_hit_idx;
               res_st_in  = vud_pkg::ST_FOUND;
               state_in   = S_DONE;
            end else if (rd_i_ff == cur_n) begin
               // list exhausted without a match
               state_in = S_DONE;
               if (can_add) begin
                  slot_sel       = cur_n;
                  slot_ctl.wr_en = 1'b1;
                  cnt_ctl.wr_en  = 1'b1;
                  cnt_wr         = cur_n + 1'b1;
                  res_idx_in     = next_ff;
                  res_st_in      = vud_pkg::ST_ADDED;
                  next_in        = next_ff + 1'b1;
               end else begin
                  res_idx_in = '0;
                  res_st_in  = vud_pkg::ST_FULL;
               end
            end else begin
               slot_ctl.rd_en = 1'b1;
               rd_i_in        = rd_i_ff + 1'b1;
               state_in       = S_SEARCH;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = res_idx_ff[vud_pkg::OUT_W-1:0];
               rsp_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         pass_ff      <= '0;
         pend_ff      <= 1'b0;
         epoch_ff     <= '0;
         next_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         pend_ff      <= pend_in;
         epoch_ff     <= epoch_in;
         next_ff      <= next_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vaddr_ff    <= vaddr_in;
      in_range_ff <= in_range_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      base_ff     <= base_in;
      n_ff        <= n_in;
      rd_i_ff     <= rd_i_in;
      res_idx_ff  <= res_idx_in;
      res_st_ff   <= res_st_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_st_ff   <= rsp_st_in;
   end

   vud_count_tbl #(
      .MAX_VERTICES     (MAX_VERTICES),
      .SLOTS_PER_VERTEX (SLOTS_PER_VERTEX)
   ) u_count_tbl (
      .clock    (clock),
      .ctl      (cnt_ctl),
      .addr     (cnt_addr),
      .wr_count (cnt_wr),
      .epoch    (epoch_ff),
      .rd_count (cnt_rd)
   );

   vud_slot_tbl #(
      .MAX_VERTICES     (MAX_VERTICES),
      .SLOTS_PER_VERTEX (SLOTS_PER_VERTEX)
   ) u_slot_tbl (
      .clock   (clock),
      .ctl     (slot_ctl),
      .addr    (slot_addr),
      .wr_idx  (next_ff),
      .u_bits  (u_ff),
      .v_bits  (v_ff),
      .hit     (slot_hit),
      .hit_idx (slot_hit_idx)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_uv_index = rsp_idx_ff;
   assign rsp_status   = rsp_st_ff;

endmodule
